>>> design/dbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dbr_pkg;

	// port widths fixed by the field ranges
	localparam int unsigned ID_W = 16;
	localparam int unsigned CNT_W = 17;
	localparam int unsigned CFG_ADDR_W = 2;
	localparam int unsigned CFG_DATA_W = 17;

	// default id width inside the network
	localparam int unsigned ID_BITS_DEF = 16;

	// widest id mask: floor log2 of the count plus a four bit digit
	localparam int unsigned MASK_W = 20;
	// holds a shift amount or a mask width up to MASK_W
	localparam int unsigned TOP_W = 5;
	// shifts 0, dw, ... up to the mask width never need more than six cells
	localparam int unsigned NUM_CELLS = 6;

	// configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_OWN_ID = 2'd0,
		REG_NODE_COUNT = 2'd1
	} reg_idx_t;

	// values derived from the configuration, shared by every cell
	typedef struct packed {
		logic [1:0] dw_log;
		logic [TOP_W-1:0] top;
		logic [MASK_W-1:0] mask;
		logic [MASK_W-1:0] me;
	} rt_cfg_t;

	// word handed from cell to cell
	typedef struct packed {
		logic vld;
		logic [ID_W-1:0] tgt;
		logic found;
		logic [MASK_W-1:0] hop;
	} rt_word_t;

endpackage

`default_nettype wire

>>> design/dbr_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module dbr_cell #(
	parameter int unsigned SLOT = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire dbr_pkg::rt_cfg_t cfg,
	input wire dbr_pkg::rt_word_t word_in,
	output dbr_pkg::rt_word_t word_out
);
	import dbr_pkg::*;

	localparam logic [TOP_W-1:0] SLOT_V = TOP_W'(SLOT);
	localparam logic [TOP_W-1:0] PREV_V = (SLOT == 0) ? TOP_W'(0) : TOP_W'(SLOT - 1);
	localparam logic [TOP_W-1:0] LIFT_ON = (SLOT == 0) ? TOP_W'(0) : TOP_W'(1);

	logic [TOP_W-1:0] shift_i;
	logic [TOP_W-1:0] shift_down;
	logic [TOP_W-1:0] lift;
	logic [MASK_W-1:0] tgt_w;
	logic [MASK_W-1:0] me_sh;
	logic [MASK_W-1:0] cmp_mask;
	logic [MASK_W-1:0] route;
	logic hit;
	logic vld_q;
	logic [ID_W-1:0] tgt_q;
	logic found_q;
	logic [MASK_W-1:0] hop_q;

	// shift of this cell is SLOT digits
	always_comb begin
		shift_i = SLOT_V << cfg.dw_log;
		shift_down = PREV_V << cfg.dw_log;
		lift = LIFT_ON << cfg.dw_log;
		tgt_w = MASK_W'(word_in.tgt);
		me_sh = cfg.me << shift_i;
		cmp_mask = (cfg.mask >> shift_i) << shift_i;
		hit = ((me_sh ^ tgt_w) & cmp_mask) == '0;
		route = ((cfg.me << lift) | (tgt_w >> shift_down)) & cfg.mask;
	end

	// valid travels with reset, payload without
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= word_in.vld;
		end
	end

	// first matching shift wins
	always_ff @(posedge clk) begin
		tgt_q <= word_in.tgt;
		found_q <= word_in.found | hit;
		if (word_in.found) begin
			hop_q <= word_in.hop;
		end else begin
			hop_q <= route;
		end
	end

	always_comb begin
		word_out.vld = vld_q;
		word_out.tgt = tgt_q;
		word_out.found = found_q;
		word_out.hop = hop_q;
	end

endmodule

`default_nettype wire

>>> design/debruijn_next_hop_router.sv
`timescale 1ns / 1ps
`default_nettype none

// next hop lookup for a de Bruijn network
// configuration: wr_en, wr_addr and wr_data write own_id (index 0) or
//   node_count (index 1); other indexes are ignored; write
//   only while no lookup is in flight
// request: a target word is taken at a clock edge with start high and busy low
// result: next_hop_id, is_self, has_parent and parent_id show for exactly one
//   cycle with done high; the receiver cannot stall, so nothing is held back
// path: a word passes the six cells of the shift chain and then one
//   output register
// throughput: one target per cycle while busy is low; the chain is fully pipelined, each cell
//   trying one digit shift and passing its word on every cycle
// reset: own_id returns to 0, node_count to 1, in-flight words are dropped
//   and busy stays high until the first clock edge after reset
module debruijn_next_hop_router #(
	parameter int unsigned ID_BITS = dbr_pkg::ID_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire logic [dbr_pkg::CFG_ADDR_W-1:0] wr_addr,
	input wire logic [dbr_pkg::CFG_DATA_W-1:0] wr_data,
	input wire logic start,
	output logic busy,
	input wire logic [dbr_pkg::ID_W-1:0] target_id,
	output logic done,
	output logic [dbr_pkg::ID_W-1:0] next_hop_id,
	output logic is_self,
	output logic has_parent,
	output logic [dbr_pkg::ID_W-1:0] parent_id
);
	import dbr_pkg::*;

	localparam int unsigned KEEP = (ID_BITS < ID_W) ? ID_BITS : ID_W;
	localparam logic [ID_W-1:0] KEEP_MASK = ID_W'((33'd1 << KEEP) - 33'd1);
	localparam int unsigned MW1 = MASK_W + 1;

	logic [ID_W-1:0] own_id_q;
	logic [CNT_W-1:0] node_count_q;
	logic busy_q;
	logic [TOP_W-1:0] lg;
	logic [TOP_W-1:0] dw;
	logic [MW1-1:0] full;
	logic [MASK_W-1:0] mask_low;
	logic [ID_W-1:0] me16;
	rt_cfg_t cfg;
	rt_word_t chain [0:NUM_CELLS];
	rt_word_t last;
	logic self_hit;
	logic [MASK_W-1:0] hop_fold;
	logic done_q;
	logic [ID_W-1:0] hop_q;
	logic self_q;
	logic parent_vld_q;
	logic [ID_W-1:0] parent_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
			node_count_q <= CNT_W'(1);
		end else if (wr_en) begin
			unique case (wr_addr)
				REG_OWN_ID: own_id_q <= wr_data[ID_W-1:0];
				REG_NODE_COUNT: node_count_q <= wr_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// busy only while coming out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;

	// floor log2, digit width and id mask
	always_comb begin
		lg = '0;
		for (int b = 1; b < CNT_W; b++) begin
			if (node_count_q[b]) begin
				lg = TOP_W'(b);
			end
		end
		if (lg < TOP_W'(3)) begin
			cfg.dw_log = 2'd0;
		end else if (lg < TOP_W'(7)) begin
			cfg.dw_log = 2'd1;
		end else begin
			cfg.dw_log = 2'd2;
		end
		dw = TOP_W'(1) << cfg.dw_log;
		cfg.top = (lg + dw) & ~(dw - TOP_W'(1));
		full = (MW1'(1) << cfg.top) - MW1'(1);
		cfg.mask = full[MASK_W-1:0];
		me16 = own_id_q & KEEP_MASK;
		cfg.me = MASK_W'(me16);
		mask_low = cfg.mask >> dw;
	end

	// word entering the chain
	always_comb begin
		chain[0].vld = start & ~busy_q;
		chain[0].tgt = target_id & KEEP_MASK;
		chain[0].found = 1'b0;
		chain[0].hop = '0;
	end

	// one cell per digit shift
	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		dbr_cell #(
			.SLOT(k)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cfg(cfg),
			.word_in(chain[k]),
			.word_out(chain[k+1])
		);
	end

	// self check and fold below the node count
	always_comb begin
		last = chain[NUM_CELLS];
		self_hit = last.tgt == me16;
		if (last.hop >= MASK_W'(node_count_q)) begin
			hop_fold = last.hop & mask_low;
		end else begin
			hop_fold = last.hop;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last.vld;
		end
	end

	always_ff @(posedge clk) begin
		hop_q <= self_hit ? me16 : hop_fold[ID_W-1:0];
		self_q <= self_hit;
		parent_vld_q <= me16 != '0;
		parent_q <= (me16 != '0) ? (me16 >> dw) : '0;
	end

	assign done = done_q;
	assign next_hop_id = hop_q;
	assign is_self = self_q;
	assign has_parent = parent_vld_q;
	assign parent_id = parent_q;

endmodule

`default_nettype wire

>>> design/dbr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dbr_checker #(
	parameter int unsigned ID_BITS = dbr_pkg::ID_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic [dbr_pkg::ID_W-1:0] target_id,
	input wire logic done,
	input wire logic [dbr_pkg::ID_W-1:0] next_hop_id,
	input wire logic is_self,
	input wire logic has_parent,
	input wire logic [dbr_pkg::ID_W-1:0] parent_id
);
	import dbr_pkg::*;

	localparam int unsigned KEEP = (ID_BITS < ID_W) ? ID_BITS : ID_W;
	localparam logic [ID_W-1:0] KEEP_MASK = ID_W'((33'd1 << KEEP) - 33'd1);

	// every accepted word gives exactly one result, and done is high for no other
	a_one_per_word: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy, 7))
		else $error("result strobe does not match accepted words");

	// with no parent (node zero), parent_id is zero
	a_no_parent: assert property (@(posedge clk) disable iff (!arst_n)
		done && !has_parent |-> parent_id == '0)
		else $error("parent id without a parent");

	// a word for this node comes back as its own id
	a_self_hop: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_self |-> next_hop_id == ($past(target_id, 7) & KEEP_MASK))
		else $error("self result does not return the target");

	// node zero matching itself routes to zero
	a_self_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_self && !has_parent |-> next_hop_id == '0)
		else $error("node zero self hop is not zero");

endmodule

bind debruijn_next_hop_router dbr_checker #(
	.ID_BITS(ID_BITS)
) u_dbr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.target_id(target_id),
	.done(done),
	.next_hop_id(next_hop_id),
	.is_self(is_self),
	.has_parent(has_parent),
	.parent_id(parent_id)
);

`default_nettype wire
